/* design/lmfs_pkg.sv */
// Shared types and constants for the LED matrix frame scanner.
// No dependencies; imported by lmfs_frame and led_matrix_frame_scanner_core.
package lmfs_pkg;

   localparam int ROWS_DEFAULT    = 7;
   localparam int COLUMNS_DEFAULT = 12;
   localparam int OP_WIDTH        = 3;
   localparam int INDEX_WIDTH     = 4;
   localparam int DATA_WIDTH      = 12;
   localparam int ROW_DRIVE_WIDTH = 7;
   // widest frame word and row count the parameters allow
   localparam int EXT_WIDTH       = 16;

   typedef enum logic [OP_WIDTH-1:0] {
      OP_SET_ROW = 3'd0,
      OP_AND_ROW = 3'd1,
      OP_OR_ROW  = 3'd2,
      OP_SET_COL = 3'd3,
      OP_AND_COL = 3'd4,
      OP_OR_COL  = 3'd5,
      OP_CLEAR   = 3'd6,
      OP_TICK    = 3'd7
   } op_type;

   typedef enum logic [1:0] {
      FUNC_SET = 2'd0,
      FUNC_AND = 2'd1,
      FUNC_OR  = 2'd2
   } func_type;

   typedef struct packed {
      logic     write;   // row or column update with a valid index
      logic     col_op;  // column update, else row update
      logic     clear;
      func_type func;
   } frame_cmd_type;

endpackage

/* design/lmfs_frame.sv */
// Frame store: one word per row, row and column set/AND/OR updates, clear,
// and one read port for the scan. Depends on lmfs_pkg.
module lmfs_frame #(
   parameter int ROWS    = lmfs_pkg::ROWS_DEFAULT,
   parameter int COLUMNS = lmfs_pkg::COLUMNS_DEFAULT,
   localparam int SW     = (ROWS > 1) ? $clog2(ROWS) : 1
) (
   input  logic                               clock,
   input  logic                               reset,
   input  lmfs_pkg::frame_cmd_type            cmd,
   input  logic [lmfs_pkg::INDEX_WIDTH-1:0]   index,
   input  logic [lmfs_pkg::DATA_WIDTH-1:0]    data,
   input  logic [SW-1:0]                      rd_row,
   output logic [COLUMNS-1:0]                 rd_word
);
   import lmfs_pkg::*;

   logic [COLUMNS-1:0]   frame_ff [ROWS];
   logic [COLUMNS-1:0]   frame_in [ROWS];
   logic [EXT_WIDTH-1:0] data_ext;
   logic [COLUMNS-1:0]   row_data;
   logic [COLUMNS-1:0]   col_mask;

   assign data_ext = EXT_WIDTH'(data);
   assign row_data = data_ext[COLUMNS-1:0];
   assign col_mask = COLUMNS'(1) << index;

   always_comb begin
      logic [COLUMNS-1:0] bit_val;
      for (int r = 0; r < ROWS; r++) begin
         frame_in[r] = frame_ff[r];
         // rows past the data width see a zero bit
         bit_val = data_ext[r] ? col_mask : '0;
         if (cmd.clear) begin
            frame_in[r] = '0;
         end else if (cmd.write && cmd.col_op) begin
            case (cmd.func)
               FUNC_SET: frame_in[r] = (frame_ff[r] & ~col_mask) | bit_val;
               FUNC_AND: frame_in[r] = frame_ff[r] & (~col_mask | bit_val);
               FUNC_OR:  frame_in[r] = frame_ff[r] | bit_val;
               default:  frame_in[r] = frame_ff[r];
            endcase
         end else if (cmd.write && (index == INDEX_WIDTH'(r))) begin
            case (cmd.func)
               FUNC_SET: frame_in[r] = row_data;
               FUNC_AND: frame_in[r] = frame_ff[r] & row_data;
               FUNC_OR:  frame_in[r] = frame_ff[r] | row_data;
               default:  frame_in[r] = frame_ff[r];
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int r = 0; r < ROWS; r++) begin
         if (reset) begin
            frame_ff[r] <= '0;
         end else begin
            frame_ff[r] <= frame_in[r];
         end
      end
   end

   assign rd_word = frame_ff[rd_row];

endmodule

/* design/led_matrix_frame_scanner_core.sv */
// LED matrix frame scanner, top level: op decode, scan state, result register.
// Depends on lmfs_pkg and lmfs_frame.
//
// Usage:
//   req_* carries one command per transfer: row or column set/AND/OR into the
//   frame store, clear, or tick. Each accepted command yields exactly one
//   transfer on rsp_*: the active-low column pattern, the one-hot row drive
//   and a bad_index flag for a row/column index out of range (frame left
//   unchanged in that case).
//   A tick advances the scan to the next row and latches that row's inverted
//   word onto the columns; a clear blanks the drive; other commands hold the
//   drive. A frame change shows on the columns only at the next tick.
//   Timing: the result is registered and appears in the cycle after the request transfer.
//   Throughput: one command per cycle while no result is stalled; all work sits between the request
//   handshake and the single result register.
//   Stall: while rsp_valid is high and rsp_ready low, req_ready is low; the
//   pending result holds. A request is taken in the same cycle the pending
//   result transfers.
//   Reset: frame cleared, drive blanked (columns all ones, rows zero), scan
//   set so the first tick shows row 0. No result is pending after reset.
module led_matrix_frame_scanner_core #(
   parameter int ROWS    = lmfs_pkg::ROWS_DEFAULT,
   parameter int COLUMNS = lmfs_pkg::COLUMNS_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic [lmfs_pkg::OP_WIDTH-1:0]         req_op,
   input  logic [lmfs_pkg::INDEX_WIDTH-1:0]      req_index,
   input  logic [lmfs_pkg::DATA_WIDTH-1:0]       req_data,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic [lmfs_pkg::DATA_WIDTH-1:0]       rsp_column_drive,
   output logic [lmfs_pkg::ROW_DRIVE_WIDTH-1:0]  rsp_row_drive,
   output logic                                  rsp_bad_index
);
   import lmfs_pkg::*;

   localparam int SW = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam logic [INDEX_WIDTH:0] ROW_LIMIT = (INDEX_WIDTH + 1)'(ROWS);
   localparam logic [INDEX_WIDTH:0] COL_LIMIT = (INDEX_WIDTH + 1)'(COLUMNS);
   localparam logic [SW-1:0]        LAST_ROW  = SW'(ROWS - 1);

   op_type              op;
   logic                accept;
   logic                row_op;
   logic                col_op;
   logic                bad;
   frame_cmd_type       cmd;
   logic [SW-1:0]       scan_next;
   logic [COLUMNS-1:0]  rd_word;
   logic [EXT_WIDTH-1:0] latch_ext;
   logic [EXT_WIDTH-1:0] row_onehot;

   logic [SW-1:0]       scan_row_ff, scan_row_in;
   logic                blanked_ff, blanked_in;
   logic [COLUMNS-1:0]  column_latch_ff, column_latch_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [DATA_WIDTH-1:0]      rsp_column_drive_ff, rsp_column_drive_in;
   logic [ROW_DRIVE_WIDTH-1:0] rsp_row_drive_ff, rsp_row_drive_in;
   logic                rsp_bad_index_ff, rsp_bad_index_in;

   assign op        = op_type'(req_op);
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   always_comb begin
      row_op   = 1'b0;
      col_op   = 1'b0;
      cmd.func = FUNC_SET;
      case (op)
         OP_SET_ROW: begin row_op = 1'b1; cmd.func = FUNC_SET; end
         OP_AND_ROW: begin row_op = 1'b1; cmd.func = FUNC_AND; end
         OP_OR_ROW:  begin row_op = 1'b1; cmd.func = FUNC_OR;  end
         OP_SET_COL: begin col_op = 1'b1; cmd.func = FUNC_SET; end
         OP_AND_COL: begin col_op = 1'b1; cmd.func = FUNC_AND; end
         OP_OR_COL:  begin col_op = 1'b1; cmd.func = FUNC_OR;  end
         default:    begin row_op = 1'b0; col_op = 1'b0; end
      endcase
      bad = (row_op && ({1'b0, req_index} >= ROW_LIMIT)) ||
            (col_op && ({1'b0, req_index} >= COL_LIMIT));
      cmd.write  = accept && (row_op || col_op) && !bad;
      cmd.col_op = col_op;
      cmd.clear  = accept && (op == OP_CLEAR);
   end

   assign scan_next = (scan_row_ff == LAST_ROW) ? '0 : scan_row_ff + SW'(1);

   lmfs_frame #(
      .ROWS    (ROWS),
      .COLUMNS (COLUMNS)
   ) u_frame (
      .clock   (clock),
      .reset   (reset),
      .cmd     (cmd),
      .index   (req_index),
      .data    (req_data),
      .rd_row  (scan_next),
      .rd_word (rd_word)
   );

   // scan state
   always_comb begin
      scan_row_in     = scan_row_ff;
      blanked_in      = blanked_ff;
      column_latch_in = column_latch_ff;
      if (accept && (op == OP_CLEAR)) begin
         scan_row_in     = LAST_ROW;
         blanked_in      = 1'b1;
         column_latch_in = '1;
      end else if (accept && (op == OP_TICK)) begin
         scan_row_in     = scan_next;
         blanked_in      = 1'b0;
         column_latch_in = ~rd_word;
      end
   end

   // result register, loaded from the updated drive state
   assign latch_ext  = EXT_WIDTH'(column_latch_in);
   assign row_onehot = EXT_WIDTH'(1) << scan_row_in;

   always_comb begin
      rsp_valid_in        = rsp_valid_ff;
      rsp_column_drive_in = rsp_column_drive_ff;
      rsp_row_drive_in    = rsp_row_drive_ff;
      rsp_bad_index_in    = rsp_bad_index_ff;
      if (accept) begin
         rsp_valid_in        = 1'b1;
         rsp_column_drive_in = latch_ext[DATA_WIDTH-1:0];
         rsp_row_drive_in    = blanked_in ? '0 : row_onehot[ROW_DRIVE_WIDTH-1:0];
         rsp_bad_index_in    = bad;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_row_ff     <= LAST_ROW;
         blanked_ff      <= 1'b1;
         column_latch_ff <= '1;
         rsp_valid_ff    <= 1'b0;
      end else begin
         scan_row_ff     <= scan_row_in;
         blanked_ff      <= blanked_in;
         column_latch_ff <= column_latch_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_column_drive_ff <= rsp_column_drive_in;
      rsp_row_drive_ff    <= rsp_row_drive_in;
      rsp_bad_index_ff    <= rsp_bad_index_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_column_drive = rsp_column_drive_ff;
   assign rsp_row_drive    = rsp_row_drive_ff;
   assign rsp_bad_index    = rsp_bad_index_ff;

   // at most one row is ever driven
   a_row_onehot: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $onehot0(rsp_row_drive))
      else $error("row drive not one-hot");

   // blank drive means columns off and scan parked on the last row
   a_blank_state: assert property (@(posedge clock) disable iff (reset)
      blanked_ff |-> (column_latch_ff == '1) && (scan_row_ff == LAST_ROW))
      else $error("blanked with live drive state");

   // frame edits never disturb the drive
   a_drive_held: assert property (@(posedge clock) disable iff (reset)
      accept && (op != OP_TICK) && (op != OP_CLEAR) |=>
         $stable(scan_row_ff) && $stable(blanked_ff) && $stable(column_latch_ff))
      else $error("drive changed on a frame edit");

endmodule
